[src/sector_cache_fill_and_lru_controller_top_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the sector cache fill and LRU controller
// Checks compile in simulation and drop out under synthesis.
// ----------------------------------------------------------------------------
`ifndef SECTOR_CACHE_FILL_AND_LRU_CONTROLLER_TOP_MACROS_SVH
`define SECTOR_CACHE_FILL_AND_LRU_CONTROLLER_TOP_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication.
`define SCF_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("scf assertion failed");
// Next-cycle implication.
`define SCF_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("scf assertion failed");
`else
`define SCF_ASSERT_IMPL(label, clk, rst, ante, cons)
`define SCF_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

[src/scf_pkg.sv]
// ----------------------------------------------------------------------------
// scf_pkg
// Shared constants, codes and types of the sector cache controller.
// ----------------------------------------------------------------------------
package scf_pkg;

   // Cache geometry and fetch limit.
   localparam int NUM_SECTORS = 4096;
   localparam int SEC_W       = 12;
   localparam int LINK_W      = 13;
   localparam int MAX_FETCH   = 64;
   localparam logic [LINK_W-1:0] NIL_LINK = LINK_W'(NUM_SECTORS);

   // Request operations.
   localparam logic [1:0] OP_FETCH  = 2'd0;
   localparam logic [1:0] OP_INVAL  = 2'd1;
   localparam logic [1:0] OP_SHRINK = 2'd2;

   // Result kinds and status codes.
   localparam logic KIND_READ = 1'b0;
   localparam logic KIND_ACK  = 1'b1;
   localparam logic [1:0] STAT_OK   = 2'd0;
   localparam logic [1:0] STAT_PAST = 2'd1;
   localparam logic [1:0] STAT_LONG = 2'd2;

   // Register indexes.
   localparam logic CSR_MAX_IO = 1'b0;
   localparam logic CSR_DEV    = 1'b1;

   // Sequencer states.
   typedef enum logic [4:0] {
      ST_CLR, ST_IDLE, ST_SCAN0, ST_SCAN1, ST_DIV, ST_BACK0, ST_BACK1,
      ST_CHUNK, ST_FWD0, ST_FWD1, ST_MARK0, ST_MARK1, ST_MARK2, ST_MARK3,
      ST_EMIT, ST_FIN, ST_INV, ST_SHR, ST_DROP0, ST_DROP1, ST_ACK
   } state_type;

endpackage

[src/scf_ram.sv]
// ----------------------------------------------------------------------------
// scf_ram
// Generic single-write, single-read memory with registered read data.
// ----------------------------------------------------------------------------
module scf_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

[src/sector_cache_fill_and_lru_controller_top.sv]
// ----------------------------------------------------------------------------
// sector_cache_fill_and_lru_controller_top
// Sector valid map, LRU list and fill planner for a sector cache.
// ----------------------------------------------------------------------------
// Channel  | Ports                       | Direction | Moves
// req_     | valid/ready + 4 fields      | in        | fetch, invalidate, shrink
// rsp_     | valid/ready + 7 fields      | out       | read commands and acks
// csr_     | we, index, wdata            | in        | max_io / device size
//
// One request at a time; a fetch scans each sector, works out the alignment
// remainder of each run, probes backward and forward and fills sectors,
// all on one read port of the sector memories.
// Invalidate clears each sector in range; shrink evicts from the LRU tail.
// After reset a clearing pass sweeps every entry of the valid map.
// A stalled result holds the sequencer only when a new result must be loaded.
`include "sector_cache_fill_and_lru_controller_top_macros.svh"

module sector_cache_fill_and_lru_controller_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_op,
   input  logic [11:0] req_first_sector,
   input  logic [12:0] req_sector_count,
   input  logic [12:0] req_keep_limit,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_kind,
   output logic [1:0]  rsp_status,
   output logic [11:0] rsp_read_first,
   output logic [8:0]  rsp_read_length,
   output logic [12:0] rsp_evicted,
   output logic [12:0] rsp_cached_now,
   output logic        rsp_last,
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [12:0] csr_wdata
);

   localparam int SW = scf_pkg::SEC_W;
   localparam int LW = scf_pkg::LINK_W;

   scf_pkg::state_type state_ff, state_in;

   logic [8:0]    max_io_ff;
   logic [12:0]   dev_reg_ff;
   logic [SW-1:0] clr_ff, clr_in;
   logic [12:0]   i_ff, i_in, end_ff, end_in;
   logic          in_run_ff, in_run_in, is_inv_ff, is_inv_in;
   logic [SW-1:0] run_first_ff, run_first_in;
   logic [12:0]   run_len_ff, run_len_in;
   logic [12:0]   off_ff, off_in, cnt_ff, cnt_in;
   logic [8:0]    rem_ff, rem_in;
   logic [SW-1:0] divsh_ff, divsh_in;
   logic [3:0]    divcnt_ff, divcnt_in;
   logic [12:0]   p_ff, p_in, endp_ff, endp_in, mk_ff, mk_in;
   logic [12:0]   keep_ff, keep_in, ev_ff, ev_in;
   logic [1:0]    ack_status_ff, ack_status_in;
   logic          pend_valid_ff, pend_valid_in;
   logic [SW-1:0] pend_first_ff, pend_first_in;
   logic [8:0]    pend_len_ff, pend_len_in;
   logic [12:0]   pend_total_ff, pend_total_in;
   logic [12:0]   total_ff, total_in;
   logic [LW-1:0] head_ff, head_in, tail_ff, tail_in;
   logic [SW-1:0] drop_addr_ff, drop_addr_in;

   logic          rsp_valid_ff, rsp_kind_ff, rsp_last_ff;
   logic [1:0]    rsp_status_ff;
   logic [11:0]   rsp_first_ff;
   logic [8:0]    rsp_len_ff;
   logic [12:0]   rsp_ev_ff, rsp_total_ff;

   // Result load bus.
   logic          out_load, out_kind, out_last;
   logic [1:0]    out_status;
   logic [11:0]   out_first;
   logic [8:0]    out_len;
   logic [12:0]   out_ev, out_total;
   logic          out_free;

   // Memory ports.
   logic [SW-1:0] rd_addr;
   logic          v_we, v_wd, valid_rd;
   logic [SW-1:0] v_wa;
   logic          p_we, n_we;
   logic [SW-1:0] p_wa, n_wa;
   logic [LW-1:0] p_wd, n_wd, prev_rd, next_rd;

   // Effective configuration.
   logic [8:0]  m_eff;
   logic [12:0] dev_eff;
   logic [13:0] req_sum, off_m_sum;
   logic [9:0]  div_r;
   logic [8:0]  once_w, len_w;
   logic [12:0] cnt_left;

   assign m_eff   = (max_io_ff == 9'd0) ? 9'd1 : max_io_ff;
   assign dev_eff = (dev_reg_ff > 13'(scf_pkg::NUM_SECTORS)) ?
                    13'(scf_pkg::NUM_SECTORS) : dev_reg_ff;
   assign req_sum   = {2'b00, req_first_sector} + {1'b0, req_sector_count};
   assign off_m_sum = {1'b0, off_ff} + {5'b0, m_eff};
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == scf_pkg::ST_IDLE);

   // Sector memories: valid map and the two LRU link arrays.
   scf_ram #(.WIDTH(1), .DEPTH(scf_pkg::NUM_SECTORS)) u_valid (
      .clock(clock), .we(v_we), .waddr(v_wa), .wdata(v_wd),
      .raddr(rd_addr), .rdata(valid_rd)
   );
   scf_ram #(.WIDTH(LW), .DEPTH(scf_pkg::NUM_SECTORS)) u_prev (
      .clock(clock), .we(p_we), .waddr(p_wa), .wdata(p_wd),
      .raddr(rd_addr), .rdata(prev_rd)
   );
   scf_ram #(.WIDTH(LW), .DEPTH(scf_pkg::NUM_SECTORS)) u_next (
      .clock(clock), .we(n_we), .waddr(n_wa), .wdata(n_wd),
      .raddr(rd_addr), .rdata(next_rd)
   );

   // Sequencer: next state, memory accesses and result loads.
   always_comb begin
      state_in = state_ff;
      clr_in = clr_ff;
      i_in = i_ff;
      end_in = end_ff;
      in_run_in = in_run_ff;
      is_inv_in = is_inv_ff;
      run_first_in = run_first_ff;
      run_len_in = run_len_ff;
      off_in = off_ff;
      cnt_in = cnt_ff;
      rem_in = rem_ff;
      divsh_in = divsh_ff;
      divcnt_in = divcnt_ff;
      p_in = p_ff;
      endp_in = endp_ff;
      mk_in = mk_ff;
      keep_in = keep_ff;
      ev_in = ev_ff;
      ack_status_in = ack_status_ff;
      pend_valid_in = pend_valid_ff;
      pend_first_in = pend_first_ff;
      pend_len_in = pend_len_ff;
      pend_total_in = pend_total_ff;
      total_in = total_ff;
      head_in = head_ff;
      tail_in = tail_ff;
      drop_addr_in = drop_addr_ff;
      rd_addr = '0;
      v_we = 1'b0;
      v_wa = '0;
      v_wd = 1'b0;
      p_we = 1'b0;
      p_wa = '0;
      p_wd = '0;
      n_we = 1'b0;
      n_wa = '0;
      n_wd = '0;
      out_load = 1'b0;
      out_kind = scf_pkg::KIND_ACK;
      out_status = scf_pkg::STAT_OK;
      out_first = '0;
      out_len = '0;
      out_ev = '0;
      out_total = total_ff;
      out_last = 1'b1;
      div_r = {rem_ff, divsh_ff[SW-1]};
      once_w = ({4'b0, m_eff} > cnt_ff) ? cnt_ff[8:0] : m_eff;
      len_w = 9'(p_ff - off_ff);
      cnt_left = ({4'b0, len_w} > cnt_ff) ? 13'd0 : cnt_ff - {4'b0, len_w};

      unique case (state_ff)
         scf_pkg::ST_CLR: begin
            v_we = 1'b1;
            v_wa = clr_ff;
            clr_in = clr_ff + 1'b1;
            if (clr_ff == SW'(scf_pkg::NUM_SECTORS - 1)) begin
               state_in = scf_pkg::ST_IDLE;
            end
         end
         scf_pkg::ST_IDLE: begin
            if (req_valid) begin
               ev_in = '0;
               ack_status_in = scf_pkg::STAT_OK;
               unique case (req_op)
                  scf_pkg::OP_FETCH: begin
                     if (req_sum > {1'b0, dev_eff}) begin
                        ack_status_in = scf_pkg::STAT_PAST;
                        state_in = scf_pkg::ST_ACK;
                     end else if (req_sector_count > 13'(scf_pkg::MAX_FETCH)) begin
                        ack_status_in = scf_pkg::STAT_LONG;
                        state_in = scf_pkg::ST_ACK;
                     end else begin
                        i_in = {1'b0, req_first_sector};
                        end_in = req_sum[12:0];
                        in_run_in = 1'b0;
                        state_in = scf_pkg::ST_SCAN0;
                     end
                  end
                  scf_pkg::OP_INVAL: begin
                     is_inv_in = 1'b1;
                     i_in = {1'b0, req_first_sector};
                     end_in = (req_sum > {1'b0, dev_eff}) ? dev_eff : req_sum[12:0];
                     if (req_sector_count != 13'd0 && {1'b0, req_first_sector} < dev_eff) begin
                        state_in = scf_pkg::ST_INV;
                     end else begin
                        state_in = scf_pkg::ST_ACK;
                     end
                  end
                  scf_pkg::OP_SHRINK: begin
                     is_inv_in = 1'b0;
                     keep_in = req_keep_limit;
                     state_in = scf_pkg::ST_SHR;
                  end
                  default: begin
                     state_in = scf_pkg::ST_ACK;
                  end
               endcase
            end
         end
         // Walk the fetch range one sector at a time.
         scf_pkg::ST_SCAN0: begin
            if (i_ff == end_ff) begin
               if (in_run_ff) begin
                  in_run_in = 1'b0;
                  off_in = {1'b0, run_first_ff};
                  cnt_in = run_len_ff;
                  rem_in = '0;
                  divsh_in = run_first_ff;
                  divcnt_in = '0;
                  state_in = scf_pkg::ST_DIV;
               end else begin
                  state_in = scf_pkg::ST_FIN;
               end
            end else begin
               rd_addr = i_ff[SW-1:0];
               state_in = scf_pkg::ST_SCAN1;
            end
         end
         scf_pkg::ST_SCAN1: begin
            i_in = i_ff + 1'b1;
            state_in = scf_pkg::ST_SCAN0;
            if (!valid_rd) begin
               if (in_run_ff) begin
                  run_len_in = run_len_ff + 1'b1;
               end else begin
                  run_first_in = i_ff[SW-1:0];
                  run_len_in = 13'd1;
                  in_run_in = 1'b1;
               end
            end else if (in_run_ff) begin
               in_run_in = 1'b0;
               off_in = {1'b0, run_first_ff};
               cnt_in = run_len_ff;
               rem_in = '0;
               divsh_in = run_first_ff;
               divcnt_in = '0;
               state_in = scf_pkg::ST_DIV;
            end
         end
         // Run start modulo the read size, one bit per cycle.
         scf_pkg::ST_DIV: begin
            if (div_r >= {1'b0, m_eff}) begin
               div_r = div_r - {1'b0, m_eff};
            end
            rem_in = div_r[8:0];
            divsh_in = {divsh_ff[SW-2:0], 1'b0};
            divcnt_in = divcnt_ff + 1'b1;
            if (divcnt_ff == 4'(SW - 1)) begin
               state_in = scf_pkg::ST_BACK0;
            end
         end
         // Extend the run backward toward alignment over uncached sectors.
         scf_pkg::ST_BACK0: begin
            if (rem_ff != 9'd0) begin
               rd_addr = SW'(off_ff - 13'd1);
               state_in = scf_pkg::ST_BACK1;
            end else begin
               state_in = scf_pkg::ST_CHUNK;
            end
         end
         scf_pkg::ST_BACK1: begin
            if (!valid_rd) begin
               off_in = off_ff - 1'b1;
               cnt_in = cnt_ff + 1'b1;
               rem_in = rem_ff - 1'b1;
               state_in = scf_pkg::ST_BACK0;
            end else begin
               state_in = scf_pkg::ST_CHUNK;
            end
         end
         // Size the next read; a short one probes forward.
         scf_pkg::ST_CHUNK: begin
            mk_in = off_ff;
            if (once_w < m_eff) begin
               p_in = off_ff + {4'b0, once_w};
               endp_in = (off_m_sum > {1'b0, dev_eff}) ? dev_eff : off_m_sum[12:0];
               state_in = scf_pkg::ST_FWD0;
            end else begin
               p_in = off_m_sum[12:0];
               state_in = scf_pkg::ST_MARK0;
            end
         end
         scf_pkg::ST_FWD0: begin
            if (p_ff < endp_ff) begin
               rd_addr = p_ff[SW-1:0];
               state_in = scf_pkg::ST_FWD1;
            end else begin
               state_in = scf_pkg::ST_MARK0;
            end
         end
         scf_pkg::ST_FWD1: begin
            if (!valid_rd) begin
               p_in = p_ff + 1'b1;
               state_in = scf_pkg::ST_FWD0;
            end else begin
               state_in = scf_pkg::ST_MARK0;
            end
         end
         // Mark one sector valid and move it to the MRU end.
         scf_pkg::ST_MARK0: begin
            rd_addr = mk_ff[SW-1:0];
            state_in = scf_pkg::ST_MARK1;
         end
         scf_pkg::ST_MARK1: begin
            if (valid_rd) begin
               if (prev_rd == scf_pkg::NIL_LINK) begin
                  head_in = next_rd;
               end else begin
                  n_we = 1'b1;
                  n_wa = prev_rd[SW-1:0];
                  n_wd = next_rd;
               end
               if (next_rd == scf_pkg::NIL_LINK) begin
                  tail_in = prev_rd;
               end else begin
                  p_we = 1'b1;
                  p_wa = next_rd[SW-1:0];
                  p_wd = prev_rd;
               end
            end else begin
               v_we = 1'b1;
               v_wa = mk_ff[SW-1:0];
               v_wd = 1'b1;
               total_in = total_ff + 1'b1;
            end
            state_in = scf_pkg::ST_MARK2;
         end
         scf_pkg::ST_MARK2: begin
            p_we = 1'b1;
            p_wa = mk_ff[SW-1:0];
            p_wd = scf_pkg::NIL_LINK;
            n_we = 1'b1;
            n_wa = mk_ff[SW-1:0];
            n_wd = head_ff;
            state_in = scf_pkg::ST_MARK3;
         end
         scf_pkg::ST_MARK3: begin
            if (head_ff != scf_pkg::NIL_LINK) begin
               p_we = 1'b1;
               p_wa = head_ff[SW-1:0];
               p_wd = mk_ff;
            end else begin
               tail_in = mk_ff;
            end
            head_in = mk_ff;
            mk_in = mk_ff + 1'b1;
            state_in = (mk_ff + 13'd1 == p_ff) ? scf_pkg::ST_EMIT : scf_pkg::ST_MARK0;
         end
         // Hand the previous read out and keep this one until the next is known.
         scf_pkg::ST_EMIT: begin
            if (!pend_valid_ff || out_free) begin
               if (pend_valid_ff) begin
                  out_load = 1'b1;
                  out_kind = scf_pkg::KIND_READ;
                  out_first = pend_first_ff;
                  out_len = pend_len_ff;
                  out_total = pend_total_ff;
                  out_last = 1'b0;
               end
               pend_valid_in = 1'b1;
               pend_first_in = off_ff[SW-1:0];
               pend_len_in = len_w;
               pend_total_in = total_ff;
               cnt_in = cnt_left;
               off_in = p_ff;
               state_in = (cnt_left != 13'd0) ? scf_pkg::ST_CHUNK : scf_pkg::ST_SCAN0;
            end
         end
         scf_pkg::ST_FIN: begin
            if (out_free) begin
               out_load = 1'b1;
               if (pend_valid_ff) begin
                  out_kind = scf_pkg::KIND_READ;
                  out_first = pend_first_ff;
                  out_len = pend_len_ff;
                  out_total = pend_total_ff;
               end
               pend_valid_in = 1'b0;
               state_in = scf_pkg::ST_IDLE;
            end
         end
         scf_pkg::ST_INV: begin
            if (i_ff < end_ff) begin
               drop_addr_in = i_ff[SW-1:0];
               state_in = scf_pkg::ST_DROP0;
            end else begin
               state_in = scf_pkg::ST_ACK;
            end
         end
         scf_pkg::ST_SHR: begin
            if (total_ff > keep_ff && tail_ff != scf_pkg::NIL_LINK) begin
               drop_addr_in = tail_ff[SW-1:0];
               state_in = scf_pkg::ST_DROP0;
            end else begin
               state_in = scf_pkg::ST_ACK;
            end
         end
         // Clear one sector and unlink it from the LRU list.
         scf_pkg::ST_DROP0: begin
            rd_addr = drop_addr_ff;
            state_in = scf_pkg::ST_DROP1;
         end
         scf_pkg::ST_DROP1: begin
            if (valid_rd) begin
               v_we = 1'b1;
               v_wa = drop_addr_ff;
               total_in = total_ff - 1'b1;
               if (prev_rd == scf_pkg::NIL_LINK) begin
                  head_in = next_rd;
               end else begin
                  n_we = 1'b1;
                  n_wa = prev_rd[SW-1:0];
                  n_wd = next_rd;
               end
               if (next_rd == scf_pkg::NIL_LINK) begin
                  tail_in = prev_rd;
               end else begin
                  p_we = 1'b1;
                  p_wa = next_rd[SW-1:0];
                  p_wd = prev_rd;
               end
            end
            if (is_inv_ff) begin
               i_in = i_ff + 1'b1;
               state_in = scf_pkg::ST_INV;
            end else begin
               ev_in = ev_ff + 1'b1;
               state_in = scf_pkg::ST_SHR;
            end
         end
         scf_pkg::ST_ACK: begin
            if (out_free) begin
               out_load = 1'b1;
               out_status = ack_status_ff;
               out_ev = ev_ff;
               state_in = scf_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = scf_pkg::ST_IDLE;
         end
      endcase
   end

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= scf_pkg::ST_CLR;
      end else begin
         state_ff <= state_in;
      end
   end

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         max_io_ff <= 9'd8;
         dev_reg_ff <= 13'd4096;
      end else if (csr_we) begin
         if (csr_index == scf_pkg::CSR_MAX_IO) begin
            max_io_ff <= csr_wdata[8:0];
         end else begin
            dev_reg_ff <= csr_wdata;
         end
      end
   end

   // Control and list registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= '0;
         in_run_ff <= 1'b0;
         is_inv_ff <= 1'b0;
         pend_valid_ff <= 1'b0;
         total_ff <= '0;
         head_ff <= scf_pkg::NIL_LINK;
         tail_ff <= scf_pkg::NIL_LINK;
      end else begin
         clr_ff <= clr_in;
         in_run_ff <= in_run_in;
         is_inv_ff <= is_inv_in;
         pend_valid_ff <= pend_valid_in;
         total_ff <= total_in;
         head_ff <= head_in;
         tail_ff <= tail_in;
      end
   end

   // Working registers of the walk.
   always_ff @(posedge clock) begin
      i_ff <= i_in;
      end_ff <= end_in;
      run_first_ff <= run_first_in;
      run_len_ff <= run_len_in;
      off_ff <= off_in;
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      divsh_ff <= divsh_in;
      divcnt_ff <= divcnt_in;
      p_ff <= p_in;
      endp_ff <= endp_in;
      mk_ff <= mk_in;
      keep_ff <= keep_in;
      ev_ff <= ev_in;
      ack_status_ff <= ack_status_in;
      pend_first_ff <= pend_first_in;
      pend_len_ff <= pend_len_in;
      pend_total_ff <= pend_total_in;
      drop_addr_ff <= drop_addr_in;
   end

   // Result output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_kind_ff <= out_kind;
         rsp_status_ff <= out_status;
         rsp_first_ff <= out_first;
         rsp_len_ff <= out_len;
         rsp_ev_ff <= out_ev;
         rsp_total_ff <= out_total;
         rsp_last_ff <= out_last;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_kind = rsp_kind_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_read_first = rsp_first_ff;
   assign rsp_read_length = rsp_len_ff;
   assign rsp_evicted = rsp_ev_ff;
   assign rsp_cached_now = rsp_total_ff;
   assign rsp_last = rsp_last_ff;

   // Checks.
   `SCF_ASSERT_NEXT(a_busy_after_req, clock, reset, req_valid && req_ready, !req_ready)
   `SCF_ASSERT_IMPL(a_total_range, clock, reset, 1'b1, total_ff <= 13'(scf_pkg::NUM_SECTORS))
   `SCF_ASSERT_IMPL(a_list_ends, clock, reset, 1'b1, (head_ff == scf_pkg::NIL_LINK) == (tail_ff == scf_pkg::NIL_LINK))
   `SCF_ASSERT_IMPL(a_read_len, clock, reset, rsp_valid && rsp_kind == scf_pkg::KIND_READ, rsp_read_length != 9'd0)

endmodule

[bench/sector_cache_fill_and_lru_controller_top_tb.sv]
// ----------------------------------------------------------------------------
// Testbench for the sector cache fill and LRU controller
// Drives fetch, invalidate and shrink requests with random gaps and result
// stalls. A predictor keeps its own copy of the valid map and LRU list and
// works out the read commands and acks of every request. The checker
// compares each result with the oldest expected one.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sector_cache_fill_and_lru_controller_top_tb;

   localparam int WATCHDOG_LIMIT = 60000;
   localparam int NSEC = scf_pkg::NUM_SECTORS;
   // Operation code with no defined meaning.
   localparam logic [1:0] OP_UNUSED = 2'd3;

   typedef struct packed {
      logic        kind;
      logic [1:0]  status;
      logic [11:0] read_first;
      logic [8:0]  read_length;
      logic [12:0] evicted;
      logic [12:0] cached_now;
      logic        last;
   } cache_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [1:0]  req_op = scf_pkg::OP_FETCH;
   logic [11:0] req_first_sector = '0;
   logic [12:0] req_sector_count = '0;
   logic [12:0] req_keep_limit = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic        rsp_kind;
   logic [1:0]  rsp_status;
   logic [11:0] rsp_read_first;
   logic [8:0]  rsp_read_length;
   logic [12:0] rsp_evicted;
   logic [12:0] rsp_cached_now;
   logic        rsp_last;
   logic        csr_we = 1'b0;
   logic        csr_index = scf_pkg::CSR_MAX_IO;
   logic [12:0] csr_wdata = '0;

   sector_cache_fill_and_lru_controller_top DUT (.*);

   // Clock with a 4 ns period.
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Predictor state: valid map, LRU links, sector count and registers.
   bit               model_valid[NSEC];
   int               model_prev[NSEC];
   int               model_next[NSEC];
   int               model_head = NSEC;
   int               model_tail = NSEC;
   int               model_cached = 0;
   int               model_max_io = 8;
   int               model_dev = 4096;
   cache_result_type expected_results[$];
   cache_result_type request_results[$];
   int               mismatch_count = 0;
   int               idle_cycles = 0;
   bit               stalls_enabled = 1'b1;
   int               stall_left = 0;

   function automatic void lru_unlink(int s);
      int p, n;
      p = model_prev[s];
      n = model_next[s];
      if (p == NSEC) model_head = n; else model_next[p] = n;
      if (n == NSEC) model_tail = p; else model_prev[n] = p;
   endfunction

   function automatic void lru_touch(int s);
      if (model_valid[s]) begin
         lru_unlink(s);
      end else begin
         model_valid[s] = 1'b1;
         model_cached++;
      end
      model_prev[s] = NSEC;
      model_next[s] = model_head;
      if (model_head != NSEC) model_prev[model_head] = s;
      else model_tail = s;
      model_head = s;
   endfunction

   function automatic void lru_drop(int s);
      if (model_valid[s]) begin
         model_valid[s] = 1'b0;
         lru_unlink(s);
         model_cached--;
      end
   endfunction

   function automatic void add_result(logic kind, logic [1:0] status, int rfirst,
                                      int rlen, int evicted, logic last);
      cache_result_type r;
      r.kind = kind;
      r.status = status;
      r.read_first = rfirst[11:0];
      r.read_length = rlen[8:0];
      r.evicted = evicted[12:0];
      r.cached_now = model_cached[12:0];
      r.last = last;
      request_results.push_back(r);
   endfunction

   // Align a run of uncached sectors back, then cut it into reads.
   function automatic void plan_run_reads(int off, int cnt, int dev, int m);
      int once, stop, p;
      while (off > 0 && (off % m) != 0 && !model_valid[off-1]) begin
         off--;
         cnt++;
      end
      while (cnt > 0) begin
         once = (cnt < m) ? cnt : m;
         // A short read grows up to the next cached sector or boundary.
         if (once < m) begin
            stop = (off + m > dev) ? dev : off + m;
            p = off + once;
            while (p < stop && !model_valid[p]) p++;
            if (p - off > once) once = p - off;
         end
         for (int i = off; i < off + once; i++) lru_touch(i);
         add_result(scf_pkg::KIND_READ, scf_pkg::STAT_OK, off, once, 0, 1'b0);
         cnt = (once > cnt) ? 0 : cnt - once;
         off += once;
      end
   endfunction

   // Work out every result of one accepted request.
   function automatic void predict_request(logic [1:0] op, int first, int cnt,
                                           int keep);
      int dev, m, ev;
      bit in_run;
      int run_first, run_len;
      dev = (model_dev > NSEC) ? NSEC : model_dev;
      m = (model_max_io == 0) ? 1 : model_max_io;
      request_results.delete();
      if (op == scf_pkg::OP_FETCH) begin
         if (first + cnt > dev) begin
            add_result(scf_pkg::KIND_ACK, scf_pkg::STAT_PAST, 0, 0, 0, 1'b1);
         end else if (cnt > scf_pkg::MAX_FETCH) begin
            add_result(scf_pkg::KIND_ACK, scf_pkg::STAT_LONG, 0, 0, 0, 1'b1);
         end else begin
            in_run = 1'b0;
            run_first = 0;
            run_len = 0;
            for (int i = first; i < first + cnt; i++) begin
               if (!model_valid[i]) begin
                  if (in_run) begin
                     run_len++;
                  end else begin
                     run_first = i;
                     run_len = 1;
                     in_run = 1'b1;
                  end
               end else if (in_run) begin
                  plan_run_reads(run_first, run_len, dev, m);
                  in_run = 1'b0;
               end
            end
            if (in_run) plan_run_reads(run_first, run_len, dev, m);
            if (request_results.size() == 0)
               add_result(scf_pkg::KIND_ACK, scf_pkg::STAT_OK, 0, 0, 0, 1'b1);
            else
               request_results[request_results.size()-1].last = 1'b1;
         end
      end else if (op == scf_pkg::OP_INVAL) begin
         if (cnt != 0 && first < dev) begin
            if (first + cnt > dev) cnt = dev - first;
            for (int i = first; i < first + cnt; i++) lru_drop(i);
         end
         add_result(scf_pkg::KIND_ACK, scf_pkg::STAT_OK, 0, 0, 0, 1'b1);
      end else if (op == scf_pkg::OP_SHRINK) begin
         ev = 0;
         while (model_cached > keep && model_tail != NSEC) begin
            lru_drop(model_tail);
            ev++;
         end
         add_result(scf_pkg::KIND_ACK, scf_pkg::STAT_OK, 0, 0, ev, 1'b1);
      end else begin
         add_result(scf_pkg::KIND_ACK, scf_pkg::STAT_OK, 0, 0, 0, 1'b1);
      end
      foreach (request_results[i]) expected_results.push_back(request_results[i]);
   endfunction

   // Result side: random stalls, then compare each accepted result.
   always @(posedge clock) begin
      cache_result_type got, want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            got = '{rsp_kind, rsp_status, rsp_read_first, rsp_read_length,
                    rsp_evicted, rsp_cached_now, rsp_last};
            if (expected_results.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("ERROR: unexpected result %p", got);
            end else begin
               want = expected_results.pop_front();
               if (got.kind !== want.kind || got.status !== want.status ||
                   got.read_first !== want.read_first ||
                   got.read_length !== want.read_length ||
                   got.evicted !== want.evicted ||
                   got.cached_now !== want.cached_now || got.last !== want.last) begin
                  mismatch_count++;
                  if (mismatch_count <= 10)
                     $display("ERROR: result mismatch expected %p actual %p", want, got);
               end
            end
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
            if (stalls_enabled && $urandom_range(0, 3) == 0)
               stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                        : $urandom_range(1, 3);
         end
      end
   end

   // Watchdog on cycles with no accepted request or result.
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
            idle_cycles <= 0;
         end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
         end else begin
            idle_cycles <= idle_cycles + 1;
         end
      end
   end

   // Send one request after a random gap and predict its results.
   task automatic send_request(logic [1:0] op, int first, int cnt, int keep);
      int gap;
      gap = 0;
      if (stalls_enabled && $urandom_range(0, 2) == 0)
         gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                           : $urandom_range(1, 3);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_op <= op;
      req_first_sector <= first[11:0];
      req_sector_count <= cnt[12:0];
      req_keep_limit <= keep[12:0];
      do @(posedge clock); while (!req_ready);
      predict_request(op, first[11:0], cnt[12:0], keep[12:0]);
   endtask

   // Drop valid and wait until every expected result has come.
   task automatic drain_results();
      req_valid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_register(logic index, int value);
      csr_we <= 1'b1;
      csr_index <= index;
      csr_wdata <= value[12:0];
      @(posedge clock);
      csr_we <= 1'b0;
      if (index == scf_pkg::CSR_MAX_IO) model_max_io = value & 'h1FF;
      else model_dev = value & 'h1FFF;
   endtask

   // Edge cases of the range checks, cache hits and LRU eviction.
   task automatic test_directed();
      send_request(scf_pkg::OP_FETCH, 0, 0, 0);
      send_request(scf_pkg::OP_FETCH, 0, 8, 0);
      send_request(scf_pkg::OP_FETCH, 3, 2, 0);
      send_request(scf_pkg::OP_FETCH, 20, 3, 0);
      send_request(scf_pkg::OP_FETCH, 10, 20, 0);
      send_request(scf_pkg::OP_FETCH, 4090, 10, 0);
      send_request(scf_pkg::OP_FETCH, 0, 65, 0);
      send_request(scf_pkg::OP_FETCH, 4095, 8191, 8191);
      send_request(scf_pkg::OP_FETCH, 4032, 64, 0);
      send_request(scf_pkg::OP_FETCH, 4095, 1, 0);
      send_request(scf_pkg::OP_INVAL, 4, 2, 0);
      send_request(scf_pkg::OP_FETCH, 5, 1, 0);
      send_request(scf_pkg::OP_INVAL, 0, 0, 0);
      send_request(scf_pkg::OP_INVAL, 4000, 200, 0);
      send_request(scf_pkg::OP_SHRINK, 0, 0, 8191);
      send_request(scf_pkg::OP_FETCH, 100, 64, 0);
      send_request(scf_pkg::OP_SHRINK, 0, 0, 10);
      send_request(OP_UNUSED, 4095, 8191, 8191);
      send_request(scf_pkg::OP_SHRINK, 4095, 8191, 0);
      drain_results();
   endtask

   // Mostly in-range fetches near a hot window, plus invalidates, shrinks
   // and noise with full-width fields.
   task automatic test_random_mix(int count);
      int pick, dev, first, cnt, keep, span;
      dev = (model_dev > NSEC) ? NSEC : model_dev;
      for (int n = 0; n < count; n++) begin
         pick = $urandom_range(0, 99);
         first = (dev > 0) ? $urandom_range(0, (dev > 512 ? 511 : dev - 1)) : 0;
         if (dev > 512 && $urandom_range(0, 3) == 0) first = $urandom_range(0, dev - 1);
         span = dev - first;
         if (span > scf_pkg::MAX_FETCH) span = scf_pkg::MAX_FETCH;
         if (pick < 65) begin
            cnt = (span == 0) ? 0 : $urandom_range(1, (span > 12 && pick < 50) ? 12 : span);
            send_request(scf_pkg::OP_FETCH, first, cnt, $urandom_range(0, 8191));
         end else if (pick < 72) begin
            send_request(scf_pkg::OP_FETCH, $urandom_range(0, 4095),
                         $urandom_range(0, 8191), $urandom_range(0, 8191));
         end else if (pick < 85) begin
            cnt = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 8191)
                                              : $urandom_range(0, 16);
            send_request(scf_pkg::OP_INVAL, first, cnt, $urandom_range(0, 8191));
         end else if (pick < 96) begin
            keep = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 8191)
                   : ((model_cached > 20) ? model_cached - $urandom_range(0, 20) : 0);
            send_request(scf_pkg::OP_SHRINK, $urandom_range(0, 4095),
                         $urandom_range(0, 8191), keep);
         end else begin
            send_request(OP_UNUSED, $urandom_range(0, 4095), $urandom_range(0, 8191),
                         $urandom_range(0, 8191));
         end
         // Hold off once mid-phase until the block has answered everything.
         if (n == count / 2) drain_results();
      end
      drain_results();
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_random_mix(30);
      write_register(scf_pkg::CSR_MAX_IO, 1);
      write_register(scf_pkg::CSR_DEV, 100);
      test_random_mix(25);
      write_register(scf_pkg::CSR_MAX_IO, 256);
      write_register(scf_pkg::CSR_DEV, 4096);
      test_random_mix(30);
      // No stalls on either side for one phase.
      stalls_enabled = 1'b0;
      write_register(scf_pkg::CSR_MAX_IO, 0);
      write_register(scf_pkg::CSR_DEV, 8191);
      test_random_mix(25);
      stalls_enabled = 1'b1;
      write_register(scf_pkg::CSR_MAX_IO, 511);
      write_register(scf_pkg::CSR_DEV, 300);
      test_random_mix(25);
      write_register(scf_pkg::CSR_MAX_IO, 3);
      write_register(scf_pkg::CSR_DEV, 0);
      send_request(scf_pkg::OP_FETCH, 0, 0, 0);
      send_request(scf_pkg::OP_FETCH, 0, 1, 0);
      send_request(scf_pkg::OP_INVAL, 0, 5, 0);
      drain_results();
      write_register(scf_pkg::CSR_DEV, 1);
      test_random_mix(15);
      repeat (50) @(posedge clock);
      if (mismatch_count == 0 && expected_results.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
